// ===== hw/rtl/srct_pkg.sv =====
// Shared constants and types for the sector range containment table.
`timescale 1ns / 1ps

package srct_pkg;

  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned SECTOR_W  = 48;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned SHIFT_W   = 9;
  localparam int unsigned SECS_W    = LEN_W + 1 - SHIFT_W;
  localparam int unsigned ENTRY_W   = 2 * SECTOR_W;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [SECTOR_W-1:0] lba_t;

  typedef struct packed {
    logic contained;
    logic added;
    logic table_full;
  } result_t;

  typedef struct packed {
    logic                 rd_en;
    idx_t                 rd_addr;
    logic                 wr_en;
    idx_t                 wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
  } mem_req_t;

endpackage

// ===== hw/rtl/srct_ram.sv =====
// Single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module srct_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/srct_engine.sv =====
// Request sequencer: range end calculation, table scan, insert and clear.
`timescale 1ns / 1ps

module srct_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 busy,
  input  logic [1:0]                           action,
  input  logic [srct_pkg::SECTOR_W-1:0]        start_sector,
  input  logic [srct_pkg::LEN_W-1:0]           length_bytes,
  output srct_pkg::mem_req_t                   mem_req,
  input  logic [srct_pkg::ENTRY_W-1:0]         mem_rd_data,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output srct_pkg::result_t                    res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t              state;
  logic [1:0]          act;
  srct_pkg::lba_t      start_q;
  srct_pkg::lba_t      last_q;
  logic                len_zero;
  srct_pkg::cnt_t      count;
  srct_pkg::cnt_t      idx;
  logic                rd_pend;
  logic                hit;
  srct_pkg::result_t   res_q;
  srct_pkg::result_t   res_next;

  logic [srct_pkg::LEN_W:0]      len_round;
  logic [srct_pkg::SECS_W-1:0]   sectors;
  logic [srct_pkg::SECTOR_W:0]   last_sum;
  srct_pkg::lba_t                last_sat;
  srct_pkg::lba_t                ent_first;
  srct_pkg::lba_t                ent_last;
  logic                          issue;
  logic                          cmp_hit;
  logic                          scan_end;
  logic                          need_add;
  logic                          has_room;
  logic                          do_write;

  assign len_round = {1'b0, length_bytes} + (srct_pkg::LEN_W + 1)'(511);
  assign sectors   = len_round[srct_pkg::LEN_W:srct_pkg::SHIFT_W];
  assign last_sum  = {1'b0, start_sector}
                   + (srct_pkg::SECTOR_W + 1)'(sectors)
                   - (srct_pkg::SECTOR_W + 1)'(1);
  assign last_sat  = last_sum[srct_pkg::SECTOR_W] ? '1
                                                   : last_sum[srct_pkg::SECTOR_W-1:0];

  assign ent_first = mem_rd_data[srct_pkg::ENTRY_W-1:srct_pkg::SECTOR_W];
  assign ent_last  = mem_rd_data[srct_pkg::SECTOR_W-1:0];

  assign issue    = (state == ST_SCAN) && (idx < count);
  assign cmp_hit  = rd_pend && (start_q >= ent_first) && (last_q <= ent_last);
  assign scan_end = (state == ST_SCAN) && !issue && !rd_pend;
  assign has_room = count < srct_pkg::CNT_W'(srct_pkg::ENTRIES);
  assign need_add = (act == srct_pkg::ACT_ADD) && !len_zero && !hit;
  assign do_write = scan_end && need_add && has_room;

  always_comb begin
    mem_req.rd_en   = issue;
    mem_req.rd_addr = idx[srct_pkg::IDX_W-1:0];
    mem_req.wr_en   = do_write;
    mem_req.wr_addr = count[srct_pkg::IDX_W-1:0];
    mem_req.wr_data = {start_q, last_q};
  end

  always_comb begin
    res_next = '0;
    unique case (act)
      srct_pkg::ACT_ADD: begin
        res_next.contained  = len_zero || hit;
        res_next.added      = need_add && has_room;
        res_next.table_full = need_add && !has_room;
      end
      srct_pkg::ACT_QUERY: begin
        res_next.contained = len_zero || hit;
      end
      default: begin
      end
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
      hit     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            act      <= action;
            start_q  <= start_sector;
            last_q   <= last_sat;
            len_zero <= (length_bytes == '0);
            idx      <= '0;
            rd_pend  <= 1'b0;
            hit      <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_pend <= issue;
          if (issue) begin
            idx <= idx + srct_pkg::CNT_W'(1);
          end
          if (cmp_hit) begin
            hit <= 1'b1;
          end
          if (scan_end) begin
            res_q <= res_next;
            if (do_write) begin
              count <= count + srct_pkg::CNT_W'(1);
            end else if (act == srct_pkg::ACT_CLEAR) begin
              count <= '0;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= srct_pkg::CNT_W'(srct_pkg::ENTRIES))
    else $error("entry count above table size");

  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    do_write |=> (count == $past(count) + srct_pkg::CNT_W'(1)))
    else $error("insert did not advance entry count");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_req.rd_en |-> (state == ST_SCAN) && (idx < count))
    else $error("read past filled entries");

  a_result_one_hot: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({res_q.contained, res_q.added, res_q.table_full}))
    else $error("conflicting result flags");

endmodule

// ===== hw/rtl/sector_range_containment_table.sv =====
// Top level: sector range containment table with entry RAM and output register.
`timescale 1ns / 1ps

// channel  valid     stall     payload
// in       in_valid  in_stall  action, start_sector, length_bytes
// out      out_valid out_stall contained, added, table_full
//
// An item is handled in order: one entry is read per cycle through the single read port
// of the RAM for each filled entry, then the last compare, the finishing step, and a
// wait in done until the result is taken, after which the engine is back in idle.
// Filled entries always occupy the lowest slots, so a fill count replaces valid bits.
// Reset empties the table at once; no clearing pass is needed.
// A new item is accepted while a finished result waits in the output register.

module sector_range_containment_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     action,
  input  logic [srct_pkg::SECTOR_W-1:0]  start_sector,
  input  logic [srct_pkg::LEN_W-1:0]     length_bytes,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           contained,
  output logic                           added,
  output logic                           table_full
);

  srct_pkg::mem_req_t              mem_req;
  logic [srct_pkg::ENTRY_W-1:0]    mem_rd_data;
  logic                            busy;
  logic                            res_valid;
  logic                            res_ready;
  srct_pkg::result_t               res;

  assign in_stall  = busy;
  assign res_ready = !out_valid || !out_stall;

  srct_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (in_valid),
    .busy         (busy),
    .action       (action),
    .start_sector (start_sector),
    .length_bytes (length_bytes),
    .mem_req      (mem_req),
    .mem_rd_data  (mem_rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  srct_ram #(
    .DEPTH (srct_pkg::ENTRIES),
    .WIDTH (srct_pkg::ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid  <= 1'b1;
      contained  <= res.contained;
      added      <= res.added;
      table_full <= res.table_full;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
